/* rtl/yuvrgb_pkg.sv */
package yuvrgb_pkg;

  localparam int unsigned MB_COLUMNS = 11;
  localparam int unsigned MB_ROWS    = 9;

  localparam logic [1:0] REG_X_OFFSET        = 2'd0;
  localparam logic [1:0] REG_Y_OFFSET        = 2'd1;
  localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd2;
  localparam logic [1:0] REG_LINE_LENGTH     = 2'd3;

  localparam logic [11:0] X_OFFSET_RST        = 12'd0;
  localparam logic [11:0] Y_OFFSET_RST        = 12'd0;
  localparam logic [2:0]  BYTES_PER_PIXEL_RST = 3'd2;
  localparam logic [13:0] LINE_LENGTH_RST     = 14'd352;

  localparam logic signed [10:0] K_Y    = 11'sd298;
  localparam logic signed [10:0] K_RV   = 11'sd409;
  localparam logic signed [10:0] K_GU   = 11'sd100;
  localparam logic signed [10:0] K_GV   = 11'sd208;
  localparam logic signed [10:0] K_BU   = 11'sd516;
  localparam logic signed [19:0] K_RND  = 20'sd128;
  localparam logic [7:0]         CH_MAX = 8'd255;

  typedef logic signed [19:0] chan_sum_t;
  typedef logic [15:0]        rgb565_t;

  function automatic logic [7:0] clamp_channel(input chan_sum_t s);
    logic [7:0] r;
    if (s < 0) begin
      r = 8'd0;
    end else if (s[18:16] != 3'd0) begin
      r = CH_MAX;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

  function automatic rgb565_t pack_rgb565(input chan_sum_t cy, input chan_sum_t cr,
                                          input chan_sum_t cg, input chan_sum_t cb);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = clamp_channel(cy + cr);
    g = clamp_channel(cy + cg);
    b = clamp_channel(cy + cb);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* rtl/yuv420_macroblock_to_rgb565_unit.sv */
// 4:2:0 macroblock to RGB565 converter.
// Input channel (in_valid/in_ready/in_sample): one byte per request, 384 per
// macroblock: four 8x8 luma blocks in quadrant order, 64 U, then 64 V bytes.
// Luma and U bytes are stored in four luma banks (one per pixel parity) and a
// U memory; each V byte reads all five memories at once and yields one quad.
// Output channel (out_valid/out_ready): four RGB565 pixels, the framebuffer
// byte offset of the quad's top-left pixel and a last-quad-of-macroblock flag.
// A taken V byte's quad passes the memory read, product and output registers.
// Throughput is one byte per cycle; luma and U bytes are always taken, V bytes
// whenever the pipeline has room, so a stalled receiver holds back only V bytes
// once three quads wait. Configuration (cfg_we/cfg_index/cfg_wdata) must be
// written only while the block idles; the block does not check it.
// Reset returns to the first byte of the top-left macroblock and loads the
// register defaults; stored samples are not cleared and need not be.
module yuv420_macroblock_to_rgb565_unit
  import yuvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [26:0] out_quad_address,
  output logic [15:0] out_pixel_top_left,
  output logic [15:0] out_pixel_top_right,
  output logic [15:0] out_pixel_bottom_left,
  output logic [15:0] out_pixel_bottom_right,
  output logic        out_macroblock_end
);

  logic [11:0] x_offset_r;
  logic [11:0] y_offset_r;
  logic [2:0]  bytes_per_pixel_r;
  logic [13:0] line_length_r;

  logic [8:0]  sample_index_r;
  logic [8:0]  sample_index_nxt;
  logic [3:0]  mb_col_r;
  logic [3:0]  mb_col_nxt;
  logic [3:0]  mb_row_r;
  logic [3:0]  mb_row_nxt;

  logic        luma_phase;
  logic        u_phase;
  logic        v_phase;
  logic        in_fire;
  logic        v_fire;
  logic        last_quad;
  logic [5:0]  quad_idx;
  logic [1:0]  wr_bank;
  logic [5:0]  wr_addr;
  logic [12:0] px;
  logic [12:0] py;

  logic        s1_valid_r;
  logic        s2_valid_r;
  logic        out_valid_r;
  logic        out_free;
  logic        s2_free;
  logic        s1_free;

  logic [7:0]  luma_rd_r [4];
  logic [7:0]  u_rd_r;
  logic [7:0]  u_mem [64];
  logic [7:0]  v_r;
  logic [12:0] px_r;
  logic [12:0] py_r;
  logic        last_s1_r;

  logic signed [9:0] yc [4];
  logic signed [8:0] d_s1;
  logic signed [8:0] e_s1;

  chan_sum_t   cy_r [4];
  chan_sum_t   cr_r;
  chan_sum_t   cg_r;
  chan_sum_t   cb_r;
  logic [15:0] ax_r;
  logic [26:0] ay_r;
  logic        last_s2_r;

  logic [26:0] quad_address_r;
  rgb565_t     pix_r [4];
  logic        mb_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r        <= X_OFFSET_RST;
      y_offset_r        <= Y_OFFSET_RST;
      bytes_per_pixel_r <= BYTES_PER_PIXEL_RST;
      line_length_r     <= LINE_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_OFFSET:        x_offset_r        <= cfg_wdata[11:0];
        REG_Y_OFFSET:        y_offset_r        <= cfg_wdata[11:0];
        REG_BYTES_PER_PIXEL: bytes_per_pixel_r <= cfg_wdata[2:0];
        REG_LINE_LENGTH:     line_length_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign luma_phase = ~sample_index_r[8];
  assign u_phase    = sample_index_r[8:6] == 3'b100;
  assign v_phase    = sample_index_r[8:6] == 3'b101;
  assign quad_idx   = sample_index_r[5:0];
  assign last_quad  = v_phase && (quad_idx == 6'd63);

  assign out_free = ~out_valid_r | out_ready;
  assign s2_free  = ~s2_valid_r | out_free;
  assign s1_free  = ~s1_valid_r | s2_free;

  assign in_ready = ~v_phase | s1_free;
  assign in_fire  = in_valid & in_ready;
  assign v_fire   = in_fire & v_phase;

  // Bank by pixel parity so each quad reads one entry from every bank.
  assign wr_bank = {sample_index_r[3], sample_index_r[0]};
  assign wr_addr = {sample_index_r[7], sample_index_r[5:4], sample_index_r[6],
                    sample_index_r[2:1]};

  assign px = 13'({mb_col_r, quad_idx[2:0], 1'b0}) + 13'(x_offset_r);
  assign py = 13'({mb_row_r, quad_idx[5:3], 1'b0}) + 13'(y_offset_r);

  always_comb begin
    sample_index_nxt = sample_index_r;
    mb_col_nxt       = mb_col_r;
    mb_row_nxt       = mb_row_r;
    if (in_fire) begin
      if (last_quad) begin
        sample_index_nxt = 9'd0;
        if (mb_col_r == 4'(MB_COLUMNS - 1)) begin
          mb_col_nxt = 4'd0;
          mb_row_nxt = (mb_row_r == 4'(MB_ROWS - 1)) ? 4'd0 : mb_row_r + 4'd1;
        end else begin
          mb_col_nxt = mb_col_r + 4'd1;
        end
      end else begin
        sample_index_nxt = sample_index_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= 9'd0;
      mb_col_r       <= 4'd0;
      mb_row_r       <= 4'd0;
    end else begin
      sample_index_r <= sample_index_nxt;
      mb_col_r       <= mb_col_nxt;
      mb_row_r       <= mb_row_nxt;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_luma_bank
    logic [7:0] mem [64];

    always_ff @(posedge clk) begin
      if (in_fire && luma_phase && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= in_sample;
      end
    end

    always_ff @(posedge clk) begin
      if (v_fire) begin
        luma_rd_r[b] <= mem[quad_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && u_phase) begin
      u_mem[quad_idx] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (v_fire) begin
      u_rd_r    <= u_mem[quad_idx];
      v_r       <= in_sample;
      px_r      <= px;
      py_r      <= py;
      last_s1_r <= last_quad;
    end
  end

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      yc[p] = $signed({2'b00, luma_rd_r[p]}) - 10'sd16;
    end
    d_s1 = $signed({1'b0, u_rd_r}) - 9'sd128;
    e_s1 = $signed({1'b0, v_r}) - 9'sd128;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_free) begin
      for (int p = 0; p < 4; p++) begin
        cy_r[p] <= chan_sum_t'(yc[p] * K_Y);
      end
      cr_r      <= chan_sum_t'(e_s1 * K_RV) + K_RND;
      cg_r      <= K_RND - chan_sum_t'(d_s1 * K_GU) - chan_sum_t'(e_s1 * K_GV);
      cb_r      <= chan_sum_t'(d_s1 * K_BU) + K_RND;
      ax_r      <= 16'(px_r * bytes_per_pixel_r);
      ay_r      <= 27'(py_r * line_length_r);
      last_s2_r <= last_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && out_free) begin
      quad_address_r <= 27'(ax_r) + ay_r;
      for (int p = 0; p < 4; p++) begin
        pix_r[p] <= pack_rgb565(cy_r[p], cr_r, cg_r, cb_r);
      end
      mb_end_r <= last_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (v_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s2_free) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_quad_address       = quad_address_r;
  assign out_pixel_top_left     = pix_r[0];
  assign out_pixel_top_right    = pix_r[1];
  assign out_pixel_bottom_left  = pix_r[2];
  assign out_pixel_bottom_right = pix_r[3];
  assign out_macroblock_end     = mb_end_r;

  a_ready_only_v: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v_phase && s1_valid_r && s2_valid_r && out_valid_r)
    else $error("input held off outside a full pipeline in V phase");

  a_grid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mb_col_r < 4'(MB_COLUMNS)) && (mb_row_r < 4'(MB_ROWS)))
    else $error("macroblock position outside grid");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_quad |=> sample_index_r == 9'd0)
    else $error("sample index not restarted after last quad");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r && $stable(v_r) && $stable(px_r))
    else $error("stalled quad lost in first stage");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_free |=> s2_valid_r && $stable(ax_r) && $stable(cr_r))
    else $error("stalled quad lost in product stage");

endmodule
